/* rtl/core/kpr_pkg.sv */
// ----------------------------------------------------------------------------
// kpr_pkg
// shared codes for the k-th present removal tree
// ----------------------------------------------------------------------------
package kpr_pkg;

  // operation carried down the chain of level cells
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // width of the rank field
  localparam int RANK_W = 11;

endpackage

/* rtl/core/kpr_level_cell.sv */
// ----------------------------------------------------------------------------
// kpr_level_cell
// one tree level: holds the child counts below its level and steps a request
// one level down, updating the chosen child on the way
// ----------------------------------------------------------------------------
module kpr_level_cell
  import kpr_pkg::*;
#(
  parameter int LEVEL = 0,
  parameter int IDX_W = 10,
  parameter int CNT_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic [IDX_W-1:0] clr_idx,
  input  logic             in_go,
  input  logic             in_op,
  input  logic [IDX_W-1:0] in_path,
  input  logic [CNT_W-1:0] in_k,
  output logic             out_go,
  output logic             out_op,
  output logic [IDX_W-1:0] out_path,
  output logic [CNT_W-1:0] out_k
);

  localparam int AW    = LEVEL + 1;
  localparam int DEPTH = 1 << AW;
  localparam int BIT   = IDX_W - 1 - LEVEL;

  logic [CNT_W-1:0] mem [DEPTH];

  logic [AW-1:0]    a_in;
  logic [AW-1:0]    a_left;
  logic [AW-1:0]    a_right;
  logic             s_go;
  logic             s_op;
  logic [IDX_W-1:0] s_path;
  logic [CNT_W-1:0] s_k;
  logic [CNT_W-1:0] rd_l;
  logic [CNT_W-1:0] rd_r;
  logic             pick;
  logic [CNT_W-1:0] wdata;
  logic [CNT_W-1:0] k_next;
  logic [IDX_W-1:0] path_next;

  // sibling pair addressed by the path prefix
  assign a_in    = in_path[IDX_W-1 -: AW];
  assign a_left  = a_in & ~AW'(1);
  assign a_right = a_in | AW'(1);

  // choose child and new count
  always_comb begin
    pick      = 1'b0;
    wdata     = '0;
    k_next    = s_k;
    path_next = s_path;
    if (s_op == OP_LOAD) begin
      pick  = s_path[BIT];
      wdata = (pick ? rd_r : rd_l) + CNT_W'(1);
    end else begin
      if (rd_l >= s_k) begin
        pick  = 1'b0;
        wdata = rd_l - CNT_W'(1);
      end else begin
        pick   = 1'b1;
        k_next = s_k - rd_l;
        wdata  = rd_r - CNT_W'(1);
      end
    end
    path_next[BIT] = pick;
  end

  // count memory: clearing pass, update write, paired read
  always_ff @(posedge clk) begin
    if (clr) begin
      mem[clr_idx[AW-1:0]] <= '0;
    end else if (s_go) begin
      mem[{s_path[IDX_W-1 -: AW] & ~AW'(1)} | AW'(pick)] <= wdata;
    end
    if (in_go) begin
      rd_l <= mem[a_left];
      rd_r <= mem[a_right];
    end
  end

  // request staging
  always_ff @(posedge clk) begin
    if (rst) begin
      s_go   <= 1'b0;
      out_go <= 1'b0;
    end else begin
      s_go   <= in_go;
      out_go <= s_go;
    end
    if (in_go) begin
      s_op   <= in_op;
      s_path <= in_path;
      s_k    <= in_k;
    end
    if (s_go) begin
      out_op   <= s_op;
      out_path <= path_next;
      out_k    <= k_next;
    end
  end

endmodule

/* rtl/core/kth_present_removal_tree_top.sv */
// ----------------------------------------------------------------------------
// kth_present_removal_tree_top
// order-statistic slot store with a count tree, one cell per tree level
// ----------------------------------------------------------------------------
// One request at a time, passed down a chain of clog2(SLOTS) level cells,
// each reading its sibling count pair and then writing the updated child.
// A load to a slot that is already present writes the value and reads the
// present bit, then returns to idle. A load to an absent slot does the
// present-bit check, the walk and the return to idle. A remove with a
// rejected rank raises out_valid with no walk, and the block returns to
// idle as it does so. An accepted remove raises out_valid after the walk,
// the value-store read and the output load, and returns to idle as it does
// so. A result held by out_stall blocks the input only when the next remove
// reaches the output. After reset a clearing pass over all 2^clog2(SLOTS)
// entries zeroes the counts and present bits; no request is taken until it
// ends.
module kth_present_removal_tree_top
  import kpr_pkg::*;
#(
  parameter int SLOTS      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [9:0]         slot_index,
  input  logic signed [31:0] item_value,
  input  logic [RANK_W-1:0]  rank,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] removed_value,
  output logic               rank_error
);

  localparam int IDX_W  = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int LEVELS = IDX_W;
  localparam int P      = 1 << IDX_W;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int KW     = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int SW     = IDX_W + 10;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRES  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_VREAD = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]            state;
  logic                  clearing;
  logic [IDX_W-1:0]      clr_idx;
  logic [CNT_W-1:0]      total;
  logic [IDX_W-1:0]      slot_r;
  logic                  op_r;
  logic [CNT_W-1:0]      k_r;
  logic                  res_err;
  logic                  present_rd;
  logic [VALUE_BITS-1:0] value_rd;
  logic                  start_go;

  logic                  present_mem [P];
  logic [VALUE_BITS-1:0] value_mem [P];

  logic                  go   [LEVELS+1];
  logic                  op   [LEVELS+1];
  logic [IDX_W-1:0]      path [LEVELS+1];
  logic [CNT_W-1:0]      kk   [LEVELS+1];

  logic                  accept;
  logic [SW-1:0]         slot_wide;
  logic                  slot_ok;
  logic [IDX_W-1:0]      slot_i;
  logic [VALUE_BITS+31:0] vext;
  logic [KW-1:0]         rank_w;
  logic [KW-1:0]         total_w;
  logic                  rank_bad;
  logic [VALUE_BITS+31:0] out_wide;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE) || clearing;
  assign slot_wide = {{IDX_W{1'b0}}, slot_index};
  assign slot_ok   = slot_wide < SW'(SLOTS);
  assign slot_i    = slot_wide[IDX_W-1:0];
  assign vext      = {{VALUE_BITS{item_value[31]}}, item_value};
  assign rank_w    = KW'(rank);
  assign total_w   = KW'(total);
  assign rank_bad  = (rank_w == '0) || (rank_w > total_w);
  // rejected ranks answer with zero
  assign out_wide  = res_err ? '0 : {32'b0, value_rd};

  // chain head
  assign go[0]   = start_go;
  assign op[0]   = op_r;
  assign path[0] = (op_r == OP_LOAD) ? slot_r : '0;
  assign kk[0]   = k_r;

  // level cells
  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    kpr_level_cell #(
      .LEVEL (l),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clearing),
      .clr_idx  (clr_idx),
      .in_go    (go[l]),
      .in_op    (op[l]),
      .in_path  (path[l]),
      .in_k     (kk[l]),
      .out_go   (go[l+1]),
      .out_op   (op[l+1]),
      .out_path (path[l+1]),
      .out_k    (kk[l+1])
    );
  end

  // present bits and value store
  always_ff @(posedge clk) begin
    if (clearing) begin
      present_mem[clr_idx] <= 1'b0;
    end else if (state == S_PRES && !present_rd) begin
      present_mem[slot_r] <= 1'b1;
    end else if (go[LEVELS] && op[LEVELS] == OP_REMOVE) begin
      present_mem[path[LEVELS]] <= 1'b0;
    end
    if (accept && mode == OP_LOAD) begin
      present_rd <= present_mem[slot_i];
    end
    if (accept && mode == OP_LOAD && slot_ok) begin
      value_mem[slot_i] <= vext[VALUE_BITS-1:0];
    end
    if (go[LEVELS]) begin
      value_rd <= value_mem[path[LEVELS]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr_idx   <= '0;
      total     <= '0;
      start_go  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start_go <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (clearing) begin
        clr_idx <= clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(P - 1)) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r   <= mode;
            slot_r <= slot_i;
            k_r    <= rank_w[CNT_W-1:0];
            if (mode == OP_LOAD) begin
              if (slot_ok) begin
                state <= S_PRES;
              end
            end else if (rank_bad) begin
              res_err  <= 1'b1;
              state    <= S_OUT;
            end else begin
              res_err  <= 1'b0;
              total    <= total - CNT_W'(1);
              start_go <= 1'b1;
              state    <= S_WALK;
            end
          end
        end
        S_PRES: begin
          if (present_rd) begin
            state <= S_IDLE;
          end else begin
            total    <= total + CNT_W'(1);
            start_go <= 1'b1;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          if (go[LEVELS]) begin
            state <= (op_r == OP_LOAD) ? S_IDLE : S_VREAD;
          end
        end
        S_VREAD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            removed_value <= out_wide[31:0];
            rank_error    <= res_err;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
